// ===== design/okt_pkg.sv =====
// ----------------------------------------------------------------------------
// okt_pkg
// Shared types and constants for the ordered key table.
// ----------------------------------------------------------------------------
package okt_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 64;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int FKEY_W    = 64;
    localparam int POS_W     = 7;

    typedef enum logic [1:0] {
        A_CREATE = 2'd0,
        A_DELETE = 2'd1,
        A_SEARCH = 2'd2,
        A_LIST   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CREATED   = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FOUND     = 3'd5,
        ST_LISTED    = 3'd6,
        ST_EMPTY     = 3'd7
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [FKEY_W-1:0]   key;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic [FKEY_W-1:0]   entry_key;
        logic [POS_W-1:0]    entry_count;
        logic                last;
    } t_rsp;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [KEY_WIDTH-1:0]  wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

    function automatic logic [FKEY_W-1:0] widen_key(input logic [KEY_WIDTH-1:0] k);
        logic [FKEY_W-1:0] w;
        w = '0;
        w[KEY_WIDTH-1:0] = k;
        return w;
    endfunction

endpackage

// ===== design/ordered_key_table_top.sv =====
// ----------------------------------------------------------------------------
// ordered_key_table_top
// Ordered table of unique keys with create, delete, search and list requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The table lives in
// one RAM with a single read port, read one entry per cycle, so a request
// keeps busy high while it walks the stored entries: a search or create
// scans from the first entry until the match or the end of the stored
// entries. A delete that matches then moves the entries behind the match
// down by one place. A list reads out every stored entry. A full create and
// an empty list keep busy low and answer on the next cycle. Results appear
// on o_rsp for one cycle with o_strobe high, in the cycle busy falls; list
// results come on consecutive cycles. The receiver has no way to stall them.
module ordered_key_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  okt_pkg::t_req     i_req,
    output logic              o_strobe,
    output okt_pkg::t_rsp     o_rsp
);
    import okt_pkg::*;

    t_mem_req              mem;
    logic [KEY_WIDTH-1:0]  rdata;

    okt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_mem    (mem),
        .i_rdata  (rdata),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    okt_ram #(
        .WIDTH  (KEY_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

endmodule

// ===== design/okt_ram.sv =====
// ----------------------------------------------------------------------------
// okt_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module okt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/okt_ctrl.sv =====
// ----------------------------------------------------------------------------
// okt_ctrl
// Sequencer: pipelined scan, shift-down on delete, append, list read-out.
// ----------------------------------------------------------------------------
module okt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  okt_pkg::t_req             i_req,
    output okt_pkg::t_mem_req         o_mem,
    input  logic [okt_pkg::KEY_WIDTH-1:0] i_rdata,
    output logic                      o_strobe,
    output okt_pkg::t_rsp             o_rsp
);
    import okt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_LIST  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_iss, n_iss;
    logic                   r_pv, n_pv;
    logic [ADDR_W-1:0]      r_pa, n_pa;
    t_action                r_act, n_act;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic                   r_strobe, n_strobe;
    t_rsp                   r_rsp, n_rsp;

    logic                   issue;
    logic                   hit;
    logic [CNT_W-1:0]       pa_next;

    assign issue   = (r_iss < r_cnt);
    assign hit     = r_pv && (i_rdata == r_key);
    assign pa_next = CNT_W'(r_pa) + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_iss    = r_iss;
        n_pv     = 1'b0;
        n_pa     = r_pa;
        n_act    = r_act;
        n_key    = r_key;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        o_mem    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act = i_req.action;
                    n_key = i_req.key[KEY_WIDTH-1:0];
                    n_iss = '0;
                    unique case (i_req.action)
                        A_CREATE: begin
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{ST_FULL, '0, '0, POS_W'(r_cnt), 1'b1};
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        A_DELETE, A_SEARCH: begin
                            n_state = S_SCAN;
                        end
                        A_LIST: begin
                            if (r_cnt == '0) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{ST_EMPTY, '0, '0, '0, 1'b1};
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                o_mem.re    = issue;
                o_mem.raddr = r_iss[ADDR_W-1:0];
                n_pv        = issue;
                n_pa        = r_iss[ADDR_W-1:0];
                if (issue) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (hit) begin
                    n_state = S_IDLE;
                    case (r_act)
                        A_CREATE: begin
                            n_strobe = 1'b1;
                            n_rsp    = '{ST_DUPLICATE, '0, '0, POS_W'(r_cnt), 1'b1};
                        end
                        A_DELETE: begin
                            n_state = S_SHIFT;
                            n_iss   = pa_next;
                            n_pv    = 1'b0;
                            o_mem.re = 1'b0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_rsp    = '{ST_FOUND, POS_W'(pa_next), '0, POS_W'(r_cnt), 1'b1};
                        end
                    endcase
                end else if (!r_pv && !issue) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_act == A_CREATE) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_cnt[ADDR_W-1:0];
                        o_mem.wdata = r_key;
                        n_cnt       = r_cnt + CNT_W'(1);
                        n_rsp       = '{ST_CREATED, '0, '0, POS_W'(n_cnt), 1'b1};
                    end else begin
                        n_rsp       = '{ST_NOT_FOUND, '0, '0, POS_W'(r_cnt), 1'b1};
                    end
                end
            end

            S_SHIFT: begin
                o_mem.re    = issue;
                o_mem.raddr = r_iss[ADDR_W-1:0];
                n_pv        = issue;
                n_pa        = r_iss[ADDR_W-1:0];
                if (issue) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (r_pv) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pa - ADDR_W'(1);
                    o_mem.wdata = i_rdata;
                end else if (!issue) begin
                    n_state  = S_IDLE;
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_strobe = 1'b1;
                    n_rsp    = '{ST_DELETED, '0, '0, POS_W'(n_cnt), 1'b1};
                end
            end

            S_LIST: begin
                o_mem.re    = issue;
                o_mem.raddr = r_iss[ADDR_W-1:0];
                n_pv        = issue;
                n_pa        = r_iss[ADDR_W-1:0];
                if (issue) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (r_pv) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{ST_LISTED, POS_W'(pa_next), widen_key(i_rdata),
                                 POS_W'(r_cnt), (pa_next == r_cnt)};
                    if (pa_next == r_cnt) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_iss    <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_iss    <= n_iss;
            r_pv     <= n_pv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_act <= n_act;
        r_key <= n_key;
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== design/okt_checker.sv =====
// ----------------------------------------------------------------------------
// okt_checker
// Port-level checks on the result stream of the ordered key table.
// ----------------------------------------------------------------------------
module okt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            busy,
    input logic            o_strobe,
    input okt_pkg::t_rsp   o_rsp
);
    import okt_pkg::*;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.entry_count <= POS_W'(DEPTH)))
        else $error("entry_count above table depth");

    a_plain_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ST_LISTED && o_rsp.status != ST_FOUND)
        |-> (o_rsp.position == '0 && o_rsp.entry_key == '0))
        else $error("position or key set on a plain status");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == ST_LISTED && o_rsp.last)
        |-> (o_rsp.position == o_rsp.entry_count))
        else $error("last listed entry not at the stored count");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.last) |=> o_strobe)
        else $error("gap inside a list burst");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.last) |-> !busy)
        else $error("busy still high with the final result");

endmodule

bind ordered_key_table_top okt_checker u_okt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
